@@ src/integer_matrix_multiply_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the integer matrix multiplier
// Clocked property wrappers used by the RTL file that checks itself.
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Check on every rising edge outside reset.
`define IMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define IMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/imm_pkg.sv @@
// ---------------------------------------------------------------------------
// Integer matrix multiplier package
// Shared widths, register indexes and the control word of the MAC unit.
// ---------------------------------------------------------------------------
package imm_pkg;

  localparam int ELEM_W    = 32;
  localparam int IDX_W     = 3;
  localparam int CFG_DIM_W = 4;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;

  // tag that travels with each operand pair through the MAC unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ src/imm_if.sv @@
// ---------------------------------------------------------------------------
// Integer matrix multiplier channels
// Valid/ready item channels for matrix elements in and product elements out.
// ---------------------------------------------------------------------------
interface imm_in_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface imm_out_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] product_value;
  logic        [IDX_W-1:0]  row_index;
  logic        [IDX_W-1:0]  col_index;
  logic                     last_flag;
  logic                     status;

  modport source (output valid, output product_value, output row_index,
                  output col_index, output last_flag, output status, input ready);
  modport sink   (input valid, input product_value, input row_index,
                  input col_index, input last_flag, input status, output ready);
endinterface

@@ src/imm_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/imm_mac.sv @@
// ---------------------------------------------------------------------------
// Integer matrix multiplier MAC unit
// Two-stage multiply-accumulate: registered product, then wrapped 32-bit sum.
// ---------------------------------------------------------------------------
module imm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imm_pkg::mac_ctl_t         ctl_i,
  input  logic [imm_pkg::ELEM_W-1:0] a_i,
  input  logic [imm_pkg::ELEM_W-1:0] b_i,
  output logic [imm_pkg::ELEM_W-1:0] acc_o,
  output logic                      done_o
);
  import imm_pkg::*;

  logic [ELEM_W-1:0] prod_r, prod_nxt;
  mac_ctl_t          ctl_r;
  logic [ELEM_W-1:0] acc_r, acc_nxt;
  logic              done_r;

  // low word of the product is the same for signed and unsigned operands
  assign prod_nxt = a_i * b_i;
  assign acc_nxt  = ctl_r.first ? prod_r : acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl_i;
      done_r <= ctl_r.valid & ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

@@ src/integer_matrix_multiply.sv @@
// ---------------------------------------------------------------------------
// Integer matrix multiplier
// Loads A then B row-major and streams out the wrapped 32-bit product A*B.
// ---------------------------------------------------------------------------
// Feed all of A (rows_a x cols_a elements) and then all of B (rows_b x cols_b
// elements), one signed element per input item, each matrix in row-major
// order. A load item that is stored gives no result. The last B item starts
// the product: elements leave row-major, one result item each, with
// row_index/col_index attached and last_flag high on the final one. For each
// product element, cols_a reads of the A and B stores (one read port each)
// feed a single multiply-accumulate unit, through the store read, the product
// register and the accumulator, and then the output load. Register values of
// 0 act as 1 and values above MAX_DIM act as MAX_DIM. While the effective
// cols_a and rows_b differ, every input item is dropped and answered by one
// result with status 1 and all other fields zero. Write configuration only
// while idle; any write to a listed register restarts loading at the first
// element of A, and writes to other indexes are ignored. The stores need no
// clearing: every entry read in a run has been written in that run.
// ---------------------------------------------------------------------------
`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  imm_in_if.sink                        in_ch,
  imm_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::CFG_DIM_W-1:0] cfg_data
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // clamp a register value to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  state_t               state_r, state_nxt;
  logic [CFG_DIM_W-1:0] rows_a_r, rows_a_nxt, cols_a_r, cols_a_nxt;
  logic [CFG_DIM_W-1:0] rows_b_r, rows_b_nxt, cols_b_r, cols_b_nxt;
  logic [CNT_W-1:0]     load_count_r, load_count_nxt;
  logic                 loading_b_r, loading_b_nxt;
  logic [DIM_W-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0]    a_base_r, a_base_nxt, a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt;
  mac_ctl_t             ctl_d_r, ctl_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0]    out_value_r, out_value_nxt;
  logic [IDX_W-1:0]     out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic                 out_last_r, out_last_nxt, out_status_r, out_status_nxt;

  logic [DIM_W-1:0]     ra, ca, rb, cb;
  logic                 mismatch;
  logic [CNT_W-1:0]     load_target;
  logic                 out_free, in_acc, last_load, last_elem;
  logic                 we_a, we_b;
  logic [ELEM_W-1:0]    rdata_a, rdata_b, acc;
  logic                 mac_done;

  assign ra          = eff_dim(rows_a_r);
  assign ca          = eff_dim(cols_a_r);
  assign rb          = eff_dim(rows_b_r);
  assign cb          = eff_dim(cols_b_r);
  assign mismatch    = (ca != rb);
  assign load_target = loading_b_r ? CNT_W'(rb) * CNT_W'(cb) : CNT_W'(ra) * CNT_W'(ca);
  assign last_load   = (load_count_r == load_target - CNT_W'(1));
  assign last_elem   = (i_r == ra - DIM_W'(1)) && (j_r == cb - DIM_W'(1));

  // output register frees up when empty or being taken this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  // a dropped item needs the output register for its status result
  assign in_ch.ready = (state_r == ST_LOAD) && (!mismatch || out_free);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign we_a = in_acc && !mismatch && !loading_b_r;
  assign we_b = in_acc && !mismatch && loading_b_r;

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (load_count_r[ADDR_W-1:0]),
    .wdata (in_ch.element_value),
    .raddr (a_addr_r),
    .rdata (rdata_a)
  );

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (load_count_r[ADDR_W-1:0]),
    .wdata (in_ch.element_value),
    .raddr (b_addr_r),
    .rdata (rdata_b)
  );

  imm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_d_r),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  always_comb begin
    state_nxt      = state_r;
    rows_a_nxt     = rows_a_r;
    cols_a_nxt     = cols_a_r;
    rows_b_nxt     = rows_b_r;
    cols_b_nxt     = cols_b_r;
    load_count_nxt = load_count_r;
    loading_b_nxt  = loading_b_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    a_base_nxt     = a_base_r;
    a_addr_nxt     = a_addr_r;
    b_addr_nxt     = b_addr_r;
    ctl_nxt        = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (mismatch) begin
            // drop the item, answer with a status result
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_row_nxt    = '0;
            out_col_nxt    = '0;
            out_last_nxt   = 1'b0;
            out_status_nxt = 1'b1;
          end else if (!last_load) begin
            load_count_nxt = load_count_r + CNT_W'(1);
          end else begin
            load_count_nxt = '0;
            loading_b_nxt  = !loading_b_r;
            if (loading_b_r) begin
              // B complete: start on product element (0,0)
              state_nxt  = ST_ISSUE;
              i_nxt      = '0;
              j_nxt      = '0;
              k_nxt      = '0;
              a_base_nxt = '0;
              a_addr_nxt = '0;
              b_addr_nxt = '0;
            end
          end
        end
      end
      ST_ISSUE: begin
        ctl_nxt.valid = 1'b1;
        ctl_nxt.first = (k_r == '0);
        ctl_nxt.last  = (k_r == ca - DIM_W'(1));
        if (ctl_nxt.last) begin
          state_nxt = ST_WAIT;
        end else begin
          k_nxt      = k_r + DIM_W'(1);
          a_addr_nxt = a_addr_r + ADDR_W'(1);
          b_addr_nxt = b_addr_r + ADDR_W'(cb);
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = acc;
          out_row_nxt    = IDX_W'(i_r);
          out_col_nxt    = IDX_W'(j_r);
          out_last_nxt   = last_elem;
          out_status_nxt = 1'b0;
          k_nxt          = '0;
          if (last_elem) begin
            state_nxt = ST_LOAD;
          end else if (j_r == cb - DIM_W'(1)) begin
            // next row of the product
            state_nxt  = ST_ISSUE;
            i_nxt      = i_r + DIM_W'(1);
            j_nxt      = '0;
            a_base_nxt = a_base_r + ADDR_W'(ca);
            a_addr_nxt = a_base_r + ADDR_W'(ca);
            b_addr_nxt = '0;
          end else begin
            state_nxt  = ST_ISSUE;
            j_nxt      = j_r + DIM_W'(1);
            a_addr_nxt = a_base_r;
            b_addr_nxt = ADDR_W'(j_r) + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // the user must make register writes only while idle, unenforced; a listed index restarts loading
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROWS_A: rows_a_nxt = cfg_data;
        REG_COLS_A: cols_a_nxt = cfg_data;
        REG_ROWS_B: rows_b_nxt = cfg_data;
        REG_COLS_B: cols_b_nxt = cfg_data;
        default: ;
      endcase
      if (cfg_index == REG_ROWS_A || cfg_index == REG_COLS_A ||
          cfg_index == REG_ROWS_B || cfg_index == REG_COLS_B) begin
        load_count_nxt = '0;
        loading_b_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      rows_a_r     <= CFG_DIM_W'(1);
      cols_a_r     <= CFG_DIM_W'(1);
      rows_b_r     <= CFG_DIM_W'(1);
      cols_b_r     <= CFG_DIM_W'(1);
      load_count_r <= '0;
      loading_b_r  <= 1'b0;
      ctl_d_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rows_a_r     <= rows_a_nxt;
      cols_a_r     <= cols_a_nxt;
      rows_b_r     <= rows_b_nxt;
      cols_b_r     <= cols_b_nxt;
      load_count_r <= load_count_nxt;
      loading_b_r  <= loading_b_nxt;
      ctl_d_r      <= ctl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // sequencer indexes and output payload
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    a_base_r     <= a_base_nxt;
    a_addr_r     <= a_addr_nxt;
    b_addr_r     <= b_addr_nxt;
    out_value_r  <= out_value_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.row_index     = out_row_r;
  assign out_ch.col_index     = out_col_r;
  assign out_ch.last_flag     = out_last_r;
  assign out_ch.status        = out_status_r;

  `IMM_ASSERT(a_done_in_wait, mac_done |-> state_r == ST_WAIT, "MAC result outside wait state")
  `IMM_ASSERT(a_k_in_range, state_r == ST_ISSUE |-> k_r < ca, "inner index past cols_a")
  `IMM_ASSERT(a_drop_status, in_acc && mismatch |=> out_valid_r && out_status_r, "dropped item without status result")
  `IMM_ASSERT(a_run_end, state_r == ST_EMIT && out_free && last_elem |=> state_r == ST_LOAD && !loading_b_r, "run end did not restart loading of A")

endmodule
